@@ hw/rtl/tlca_pkg.sv @@
// Shared types and constants for the binary-lifting LCA unit.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none
package tlca_pkg;

	localparam int NODE_W  = 10;
	localparam int DEPTH_W = 11;
	localparam logic [DEPTH_W-1:0] DEPTH_MAX = 11'h7FF;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_QUERY  = 1'b1;

	typedef struct packed {
		logic              func;
		logic [NODE_W-1:0] node_a;
		logic [NODE_W-1:0] node_b;
	} req_item_t;

	typedef struct packed {
		logic [NODE_W-1:0]  common_ancestor;
		logic [DEPTH_W-1:0] distance;
	} rsp_item_t;

	// Datapath step codes issued by the controller.
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] STEP_NONE      = 4'd0;
	localparam logic [STEP_W-1:0] STEP_LOAD      = 4'd1;
	localparam logic [STEP_W-1:0] STEP_INS_DEPTH = 4'd2;
	localparam logic [STEP_W-1:0] STEP_INS_LEVEL = 4'd3;
	localparam logic [STEP_W-1:0] STEP_Q_DEPTH   = 4'd4;
	localparam logic [STEP_W-1:0] STEP_Q_UP_ANC  = 4'd5;
	localparam logic [STEP_W-1:0] STEP_Q_UP_CMP  = 4'd6;
	localparam logic [STEP_W-1:0] STEP_Q_JUMP    = 4'd7;
	localparam logic [STEP_W-1:0] STEP_Q_ROOT    = 4'd8;
	localparam logic [STEP_W-1:0] STEP_OUT       = 4'd9;

	typedef struct packed {
		logic [STEP_W-1:0] step;
	} cmd_t;

	typedef struct packed {
		logic query;     // current item is a query
		logic node_zero; // first node is the sentinel
		logic lvl_zero;  // level counter at 0
		logic lvl_last;  // level counter at LEVELS-1
		logic meet;      // lifted node equals the other node
	} status_t;

endpackage
`default_nettype wire

@@ hw/rtl/tlca_ram.sv @@
// Generic single-write, dual-read RAM with registered read data.
// Write-first: a read of the address being written returns the new data.
`default_nettype none
module tlca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire [$clog2(DEPTH)-1:0]  waddr,
	input  wire [WIDTH-1:0]          wdata,
	input  wire                      re0,
	input  wire [$clog2(DEPTH)-1:0]  raddr0,
	output logic [WIDTH-1:0]         rdata0,
	input  wire                      re1,
	input  wire [$clog2(DEPTH)-1:0]  raddr1,
	output logic [WIDTH-1:0]         rdata1
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re0) begin
			rdata0 <= (we && waddr == raddr0) ? wdata : mem_q[raddr0];
		end
		if (re1) begin
			rdata1 <= (we && waddr == raddr1) ? wdata : mem_q[raddr1];
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/tlca_ctrl.sv @@
// Sequencer for the LCA unit: walks insert and query steps and owns the
// request/response handshakes. Depends on tlca_pkg.
`default_nettype none
module tlca_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  wire               rsp_ready,
	input  tlca_pkg::status_t status,
	output tlca_pkg::cmd_t    cmd
);
	import tlca_pkg::*;

	localparam logic [3:0] S_IDLE      = 4'd0;
	localparam logic [3:0] S_DEPTH     = 4'd1;
	localparam logic [3:0] S_INS_LEVEL = 4'd2;
	localparam logic [3:0] S_Q_UP_ANC  = 4'd3;
	localparam logic [3:0] S_Q_UP_CMP  = 4'd4;
	localparam logic [3:0] S_Q_JUMP    = 4'd5;
	localparam logic [3:0] S_Q_ROOT    = 4'd6;
	localparam logic [3:0] S_OUT       = 4'd7;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       rsp_valid_q;
	logic       can_load;

	assign can_load  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_d  = state_q;
		cmd.step = STEP_NONE;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.step = STEP_LOAD;
					state_d  = S_DEPTH;
				end
			end
			S_DEPTH: begin
				if (status.query) begin
					cmd.step = STEP_Q_DEPTH;
					state_d  = S_Q_UP_ANC;
				end else begin
					cmd.step = STEP_INS_DEPTH;
					state_d  = status.node_zero ? S_OUT : S_INS_LEVEL;
				end
			end
			S_INS_LEVEL: begin
				cmd.step = STEP_INS_LEVEL;
				if (status.lvl_last) begin
					state_d = S_OUT;
				end
			end
			S_Q_UP_ANC: begin
				cmd.step = STEP_Q_UP_ANC;
				state_d  = S_Q_UP_CMP;
			end
			S_Q_UP_CMP: begin
				cmd.step = STEP_Q_UP_CMP;
				if (status.lvl_zero) begin
					state_d = status.meet ? S_OUT : S_Q_JUMP;
				end else begin
					state_d = S_Q_UP_ANC;
				end
			end
			S_Q_JUMP: begin
				cmd.step = STEP_Q_JUMP;
				if (status.lvl_zero) begin
					state_d = S_Q_ROOT;
				end
			end
			S_Q_ROOT: begin
				cmd.step = STEP_Q_ROOT;
				state_d  = S_OUT;
			end
			S_OUT: begin
				if (can_load) begin
					cmd.step = STEP_OUT;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.step == STEP_OUT) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/tlca_dpath.sv @@
// Datapath of the LCA unit: depth and ancestor memories, node registers,
// level counter and result register. Depends on tlca_pkg and tlca_ram.
`default_nettype none
module tlca_dpath #(
	parameter int NODES  = 1024,
	parameter int LEVELS = 10
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  tlca_pkg::cmd_t      cmd,
	input  tlca_pkg::req_item_t req,
	output tlca_pkg::status_t   status,
	output tlca_pkg::rsp_item_t rsp
);
	import tlca_pkg::*;

	localparam int NW        = $clog2(NODES);
	localparam int LW        = $clog2(LEVELS);
	localparam int AW        = NW + LW;
	localparam int ANC_DEPTH = NODES << LW;
	localparam logic [LW-1:0] LVL_TOP = LW'(LEVELS - 1);

	// Node numbers at or beyond NODES act as the sentinel.
	function automatic logic [NW-1:0] node_idx(input logic [NODE_W-1:0] n);
		return (32'(n) < NODES) ? NW'(n) : '0;
	endfunction

	function automatic logic [AW-1:0] anc_addr(input logic [NW-1:0] n,
	                                           input logic [LW-1:0] l);
		return {n, l};
	endfunction

	// Memory ports
	logic               dep_we, dep_re0, dep_re1;
	logic [NW-1:0]      dep_waddr, dep_raddr0, dep_raddr1;
	logic [DEPTH_W-1:0] dep_wdata, dep_rdata0, dep_rdata1;
	logic               anc_we, anc_re0, anc_re1;
	logic [AW-1:0]      anc_waddr, anc_raddr0, anc_raddr1;
	logic [NW-1:0]      anc_wdata, anc_rdata0, anc_rdata1;
	logic [NW-1:0]      anc_node0, anc_node1;

	// Registers
	logic               query_q;
	logic [NW-1:0]      a_q, b_q, p_q, l_q;
	logic [DEPTH_W-1:0] db_q, d_q;
	logic [DEPTH_W:0]   sum_q;
	logic [LW-1:0]      lvl_q;
	logic               dz0_q, dz1_q, az0_q, az1_q;
	rsp_item_t          res_q;

	// Next values
	logic               query_d;
	logic [NW-1:0]      a_d, b_d, p_d, l_d;
	logic [DEPTH_W-1:0] db_d, d_d;
	logic [DEPTH_W:0]   sum_d;
	logic [LW-1:0]      lvl_d;
	rsp_item_t          res_d;

	// Read data with the sentinel row forced to zero
	logic [DEPTH_W-1:0] dep0, dep1, dsat;
	logic [NW-1:0]      anc0, anc1;
	logic [NW-1:0]      up_next, ja, jb;
	logic [DEPTH_W+1:0] dist_w;

	assign dep0 = dz0_q ? '0 : dep_rdata0;
	assign dep1 = dz1_q ? '0 : dep_rdata1;
	assign anc0 = az0_q ? '0 : anc_rdata0;
	assign anc1 = az1_q ? '0 : anc_rdata1;

	assign dsat    = (dep1 == DEPTH_MAX) ? DEPTH_MAX : dep1 + 1'b1;
	assign up_next = (dep0 >= db_q) ? p_q : a_q;
	assign ja      = (anc0 != anc1) ? anc0 : a_q;
	assign jb      = (anc0 != anc1) ? anc1 : b_q;
	assign dist_w  = {1'b0, sum_q} - {1'b0, dep0, 1'b0};

	assign anc_node0 = anc_raddr0[AW-1:LW];
	assign anc_node1 = anc_raddr1[AW-1:LW];

	assign status.query     = query_q;
	assign status.node_zero = (a_q == '0);
	assign status.lvl_zero  = (lvl_q == '0);
	assign status.lvl_last  = (lvl_q == LVL_TOP);
	assign status.meet      = (up_next == b_q);

	assign rsp = res_q;

	always_comb begin
		dep_we = 1'b0; dep_waddr = '0; dep_wdata = '0;
		dep_re0 = 1'b0; dep_raddr0 = '0; dep_re1 = 1'b0; dep_raddr1 = '0;
		anc_we = 1'b0; anc_waddr = '0; anc_wdata = '0;
		anc_re0 = 1'b0; anc_raddr0 = '0; anc_re1 = 1'b0; anc_raddr1 = '0;
		query_d = query_q;
		a_d = a_q; b_d = b_q; p_d = p_q; l_d = l_q;
		db_d = db_q; d_d = d_q; sum_d = sum_q; lvl_d = lvl_q;
		res_d = res_q;
		case (cmd.step)
			STEP_LOAD: begin
				query_d    = (req.func == FUNC_QUERY);
				a_d        = node_idx(req.node_a);
				b_d        = node_idx(req.node_b);
				dep_re0    = 1'b1;
				dep_raddr0 = node_idx(req.node_a);
				dep_re1    = 1'b1;
				dep_raddr1 = node_idx(req.node_b);
			end
			STEP_INS_DEPTH: begin
				// The sentinel is never written; its insert reports depth 0.
				if (a_q != '0) begin
					dep_we    = 1'b1;
					dep_waddr = a_q;
					dep_wdata = dsat;
					anc_we    = 1'b1;
					anc_waddr = anc_addr(a_q, '0);
					anc_wdata = b_q;
					d_d       = dsat;
				end else begin
					d_d = '0;
				end
				p_d        = b_q;
				lvl_d      = LW'(1);
				anc_re0    = 1'b1;
				anc_raddr0 = anc_addr(b_q, '0);
			end
			STEP_INS_LEVEL: begin
				anc_we     = 1'b1;
				anc_waddr  = anc_addr(a_q, lvl_q);
				anc_wdata  = anc0;
				p_d        = anc0;
				anc_re0    = 1'b1;
				anc_raddr0 = anc_addr(anc0, lvl_q);
				lvl_d      = lvl_q + 1'b1;
			end
			STEP_Q_DEPTH: begin
				// Keep the deeper node in a.
				sum_d = {1'b0, dep0} + {1'b0, dep1};
				lvl_d = LVL_TOP;
				anc_re0 = 1'b1;
				if (dep0 < dep1) begin
					a_d        = b_q;
					b_d        = a_q;
					db_d       = dep0;
					anc_raddr0 = anc_addr(b_q, LVL_TOP);
				end else begin
					db_d       = dep1;
					anc_raddr0 = anc_addr(a_q, LVL_TOP);
				end
			end
			STEP_Q_UP_ANC: begin
				p_d        = anc0;
				dep_re0    = 1'b1;
				dep_raddr0 = anc0;
			end
			STEP_Q_UP_CMP: begin
				a_d = up_next;
				if (lvl_q == '0) begin
					if (up_next == b_q) begin
						l_d        = b_q;
						dep_re0    = 1'b1;
						dep_raddr0 = b_q;
					end else begin
						lvl_d      = LVL_TOP;
						anc_re0    = 1'b1;
						anc_raddr0 = anc_addr(up_next, LVL_TOP);
						anc_re1    = 1'b1;
						anc_raddr1 = anc_addr(b_q, LVL_TOP);
					end
				end else begin
					lvl_d      = lvl_q - 1'b1;
					anc_re0    = 1'b1;
					anc_raddr0 = anc_addr(up_next, lvl_q - 1'b1);
				end
			end
			STEP_Q_JUMP: begin
				a_d     = ja;
				b_d     = jb;
				anc_re0 = 1'b1;
				if (lvl_q == '0) begin
					anc_raddr0 = anc_addr(ja, '0);
				end else begin
					lvl_d      = lvl_q - 1'b1;
					anc_raddr0 = anc_addr(ja, lvl_q - 1'b1);
					anc_re1    = 1'b1;
					anc_raddr1 = anc_addr(jb, lvl_q - 1'b1);
				end
			end
			STEP_Q_ROOT: begin
				l_d        = anc0;
				dep_re0    = 1'b1;
				dep_raddr0 = anc0;
			end
			STEP_OUT: begin
				if (query_q) begin
					res_d.common_ancestor = NODE_W'(l_q);
					if (dist_w[DEPTH_W+1]) begin
						res_d.distance = '0;
					end else if (dist_w[DEPTH_W]) begin
						res_d.distance = DEPTH_MAX;
					end else begin
						res_d.distance = dist_w[DEPTH_W-1:0];
					end
				end else begin
					res_d.common_ancestor = '0;
					res_d.distance        = d_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Control flags: remember which reads hit the sentinel row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dz0_q <= 1'b1;
			dz1_q <= 1'b1;
			az0_q <= 1'b1;
			az1_q <= 1'b1;
		end else begin
			if (dep_re0) dz0_q <= (dep_raddr0 == '0);
			if (dep_re1) dz1_q <= (dep_raddr1 == '0);
			if (anc_re0) az0_q <= (anc_node0 == '0);
			if (anc_re1) az1_q <= (anc_node1 == '0);
		end
	end

	always_ff @(posedge clk) begin
		query_q <= query_d;
		a_q     <= a_d;
		b_q     <= b_d;
		p_q     <= p_d;
		l_q     <= l_d;
		db_q    <= db_d;
		d_q     <= d_d;
		sum_q   <= sum_d;
		lvl_q   <= lvl_d;
		res_q   <= res_d;
	end

	tlca_ram #(
		.WIDTH (DEPTH_W),
		.DEPTH (NODES)
	) u_depth_ram (
		.clk    (clk),
		.we     (dep_we),
		.waddr  (dep_waddr),
		.wdata  (dep_wdata),
		.re0    (dep_re0),
		.raddr0 (dep_raddr0),
		.rdata0 (dep_rdata0),
		.re1    (dep_re1),
		.raddr1 (dep_raddr1),
		.rdata1 (dep_rdata1)
	);

	tlca_ram #(
		.WIDTH (NW),
		.DEPTH (ANC_DEPTH)
	) u_anc_ram (
		.clk    (clk),
		.we     (anc_we),
		.waddr  (anc_waddr),
		.wdata  (anc_wdata),
		.re0    (anc_re0),
		.raddr0 (anc_raddr0),
		.rdata0 (anc_rdata0),
		.re1    (anc_re1),
		.raddr1 (anc_raddr1),
		.rdata1 (anc_rdata1)
	);

endmodule
`default_nettype wire

@@ hw/rtl/tree_lca_binary_lifting_unit.sv @@
// Binary-lifting lowest-common-ancestor unit, top level.
// An insert of node 0 skips the level fill, and a query skips the joint lift when the
// lifted node lands on the other node.
// Throughput: one item at a time, set by the chain of dependent memory reads; the next item
// is accepted from the cycle in which rsp_valid rises, even while the result waits on rsp.
// Reset (arst_n, asynchronous) clears control only; no clearing pass is run.
`default_nettype none
module tree_lca_binary_lifting_unit #(
	parameter int NODES  = 1024,
	parameter int LEVELS = 10
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 req_valid,
	output logic                req_ready,
	input  tlca_pkg::req_item_t req,
	output logic                rsp_valid,
	input  wire                 rsp_ready,
	output tlca_pkg::rsp_item_t rsp
);
	import tlca_pkg::*;

	// The controller walks one item through its steps: an insert reads the
	// parent's depth, then fills the ancestor row one level per cycle, each
	// level reading the entry written by the level before. A query reads both
	// depths, lifts the deeper node level by level (ancestor read, then depth
	// read), then lifts both nodes together while their ancestors differ, and
	// finally reads the depth of the common ancestor to form the distance.
	//
	// Node 0 is the sentinel: its depth and ancestor row are never written,
	// and the datapath forces any read of them to zero, so the memories need
	// no initialization.

	cmd_t    cmd;
	status_t status;

	tlca_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.status    (status),
		.cmd       (cmd)
	);

	tlca_dpath #(
		.NODES  (NODES),
		.LEVELS (LEVELS)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.status (status),
		.rsp    (rsp)
	);

endmodule
`default_nettype wire

@@ hw/rtl/tlca_checker.sv @@
// Port-level checker for the LCA unit and its bind to the top level.
// Depends on tlca_pkg.
`default_nettype none
module tlca_checker (
	input wire                 clk,
	input wire                 arst_n,
	input wire                 req_valid,
	input wire                 req_ready,
	input tlca_pkg::req_item_t req,
	input wire                 rsp_valid,
	input wire                 rsp_ready,
	input tlca_pkg::rsp_item_t rsp
);
	import tlca_pkg::*;

	logic [1:0] pending_q;
	logic       last_func_q;
	logic       req_fire, rsp_fire;

	assign req_fire = req_valid && req_ready;
	assign rsp_fire = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q   <= 2'd0;
			last_func_q <= FUNC_INSERT;
		end else begin
			pending_q <= pending_q + {1'b0, req_fire} - {1'b0, rsp_fire};
			if (req_fire) last_func_q <= req.func;
		end
	end

	// A stalled result holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("rsp changed while stalled");

	// Every result answers an accepted item.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pending_q != 2'd0)
		else $error("result without an outstanding item");

	// At most one item in work and one result waiting.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_fire && !rsp_fire |-> pending_q != 2'd2)
		else $error("too many items outstanding");

	// An insert answers with ancestor 0.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && pending_q == 2'd1 && last_func_q == FUNC_INSERT
			|-> rsp.common_ancestor == '0)
		else $error("insert result with nonzero ancestor");

endmodule

bind tree_lca_binary_lifting_unit tlca_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
`default_nettype wire

@@ test/testbench.sv @@
// Self-checking bench for tree_lca_binary_lifting_unit: tree inserts and LCA queries.
// It keeps a mirror of the depth and ancestor tables and checks each result against it.
// Depends on tlca_pkg for the item types, the operation codes and the depth limit.
module testbench;
	import tlca_pkg::*;

	localparam int TREE_NODES       = 1024;
	localparam int LIFT_LEVELS      = 10;
	localparam int RANDOM_ITEMS     = 1200;
	localparam int LONG_HOLD_AT     = 300;  // result count at which the receiver holds off
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES    = 40;   // longer than the slowest query latency
	localparam int STALL_LIMIT      = 2000; // cycles with no handshake on either side

	// One row of the opening stimulus. When fixed is set, want is the expected result;
	// otherwise the mirror supplies it.
	typedef struct packed {
		req_item_t stim;
		logic      fixed;
		rsp_item_t want;
	} directed_row_t;

	typedef struct packed {
		req_item_t stim;
		rsp_item_t want;
	} pending_t;

	localparam int DIRECTED_ROWS = 21;
	localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
		// Fresh after reset only the sentinel exists.
		'{'{FUNC_QUERY,  10'd0,    10'd0},    1'b1, '{10'd0, 11'd0}},
		// An insert of the sentinel is ignored.
		'{'{FUNC_INSERT, 10'd0,    10'd0},    1'b1, '{10'd0, 11'd0}},
		'{'{FUNC_INSERT, 10'd1,    10'd0},    1'b1, '{10'd0, 11'd1}},
		'{'{FUNC_INSERT, 10'd1023, 10'd1},    1'b1, '{10'd0, 11'd2}},
		'{'{FUNC_INSERT, 10'd512,  10'd1023}, 1'b1, '{10'd0, 11'd3}},
		'{'{FUNC_INSERT, 10'd2,    10'd1},    1'b1, '{10'd0, 11'd2}},
		'{'{FUNC_QUERY,  10'd512,  10'd2},    1'b0, '{10'd0, 11'd0}},
		'{'{FUNC_QUERY,  10'd2,    10'd512},  1'b0, '{10'd0, 11'd0}},
		'{'{FUNC_QUERY,  10'd1023, 10'd1023}, 1'b0, '{10'd0, 11'd0}},
		'{'{FUNC_QUERY,  10'd512,  10'd1},    1'b0, '{10'd0, 11'd0}},
		'{'{FUNC_QUERY,  10'd512,  10'd0},    1'b0, '{10'd0, 11'd0}},
		'{'{FUNC_QUERY,  10'd0,    10'd512},  1'b0, '{10'd0, 11'd0}},
		// A second root with alternating bit patterns.
		'{'{FUNC_INSERT, 10'd341,  10'd0},    1'b1, '{10'd0, 11'd1}},
		'{'{FUNC_INSERT, 10'd682,  10'd341},  1'b1, '{10'd0, 11'd2}},
		'{'{FUNC_QUERY,  10'd682,  10'd512},  1'b0, '{10'd0, 11'd0}},
		'{'{FUNC_INSERT, 10'd0,    10'd1023}, 1'b1, '{10'd0, 11'd0}},
		// Re-insert of node 2 under a deeper parent.
		'{'{FUNC_INSERT, 10'd2,    10'd512},  1'b1, '{10'd0, 11'd4}},
		'{'{FUNC_QUERY,  10'd2,    10'd1023}, 1'b0, '{10'd0, 11'd0}},
		'{'{FUNC_INSERT, 10'd3,    10'd2},    1'b1, '{10'd0, 11'd5}},
		'{'{FUNC_QUERY,  10'd3,    10'd682},  1'b0, '{10'd0, 11'd0}},
		'{'{FUNC_QUERY,  10'd1023, 10'd3},    1'b0, '{10'd0, 11'd0}}
	};

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_ready;
	req_item_t req;
	logic      rsp_valid;
	logic      rsp_ready;
	rsp_item_t rsp;

	// Mirror of the block's tables, plus the list of nodes inserted so far.
	logic [DEPTH_W-1:0] depth_mirror [TREE_NODES];
	logic [NODE_W-1:0]  jump_mirror [TREE_NODES][LIFT_LEVELS];
	bit                 present [TREE_NODES];
	logic [NODE_W-1:0]  placed [$];
	logic [NODE_W-1:0]  last_fresh;

	pending_t pending_results [$];
	int       items_sent;
	int       results_seen;
	int       mismatch_count;

	tree_lca_binary_lifting_unit #(
		.NODES (TREE_NODES),
		.LEVELS(LIFT_LEVELS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Binary-lifting search over the mirror: lift the deeper node to the other's depth,
	// then lift both while their ancestors differ.
	function automatic logic [NODE_W-1:0] find_common_ancestor(logic [NODE_W-1:0] a,
			logic [NODE_W-1:0] b);
		logic [NODE_W-1:0] swap;
		logic [NODE_W-1:0] up_a;
		logic [NODE_W-1:0] up_b;
		int lvl;
		if (depth_mirror[a] < depth_mirror[b]) begin
			swap = a;
			a    = b;
			b    = swap;
		end
		for (lvl = LIFT_LEVELS - 1; lvl >= 0; lvl--) begin
			up_a = jump_mirror[a][lvl];
			if (depth_mirror[up_a] >= depth_mirror[b])
				a = up_a;
		end
		if (a == b)
			return b;
		for (lvl = LIFT_LEVELS - 1; lvl >= 0; lvl--) begin
			up_a = jump_mirror[a][lvl];
			up_b = jump_mirror[b][lvl];
			if (up_a != up_b) begin
				a = up_a;
				b = up_b;
			end
		end
		return jump_mirror[a][0];
	endfunction

	// Applies one accepted item to the mirror and returns the result it must produce.
	function automatic rsp_item_t apply_tree_op(req_item_t item);
		rsp_item_t         result;
		logic [NODE_W-1:0] meet;
		int                new_depth;
		int                span;
		int                lvl;
		result = '0;
		if (item.func == FUNC_INSERT) begin
			// The sentinel is never written.
			if (item.node_a != '0) begin
				new_depth = int'(depth_mirror[item.node_b]) + 1;
				if (new_depth > int'(DEPTH_MAX))
					new_depth = int'(DEPTH_MAX);
				depth_mirror[item.node_a]   = DEPTH_W'(new_depth);
				jump_mirror[item.node_a][0] = item.node_b;
				for (lvl = 1; lvl < LIFT_LEVELS; lvl++)
					jump_mirror[item.node_a][lvl] =
						jump_mirror[jump_mirror[item.node_a][lvl - 1]][lvl - 1];
				if (!present[item.node_a]) begin
					present[item.node_a] = 1'b1;
					placed = {placed, item.node_a};
				end
				result.distance = DEPTH_W'(new_depth);
			end
		end else begin
			meet = find_common_ancestor(item.node_a, item.node_b);
			span = int'(depth_mirror[item.node_a]) + int'(depth_mirror[item.node_b])
				- 2 * int'(depth_mirror[meet]);
			// A malformed table can push the distance out of range.
			if (span < 0)
				span = 0;
			if (span > int'(DEPTH_MAX))
				span = int'(DEPTH_MAX);
			result.common_ancestor = meet;
			result.distance        = DEPTH_W'(span);
		end
		return result;
	endfunction

	function automatic logic [NODE_W-1:0] pick_placed();
		return placed[$urandom_range(0, placed.size() - 1)];
	endfunction

	// Parents lean toward the newest node so that the trees grow deep.
	function automatic logic [NODE_W-1:0] pick_parent();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return last_fresh;
		if (roll < 92)
			return pick_placed();
		return '0;
	endfunction

	// Random item that only names nodes already inserted (or the sentinel).
	function automatic req_item_t random_tree_op();
		req_item_t         item;
		logic [NODE_W-1:0] fresh;
		int                roll;
		int                pick;
		roll        = $urandom_range(0, 99);
		item.func   = FUNC_INSERT;
		item.node_a = pick_placed();
		item.node_b = jump_mirror[item.node_a][0];
		if (roll < 40 && placed.size() < TREE_NODES - 1) begin
			do
				fresh = NODE_W'($urandom_range(1, TREE_NODES - 1));
			while (present[fresh]);
			item.node_a = fresh;
			item.node_b = pick_parent();
			last_fresh  = fresh;
		end else if (roll < 44) begin
			// Re-insert under the node's own parent keeps the tree well formed.
		end else if (roll < 47) begin
			// Re-insert anywhere, possibly under a descendant.
			item.node_b = pick_placed();
		end else if (roll < 50) begin
			item.node_a = '0;
		end else begin
			item.func = FUNC_QUERY;
			pick      = $urandom_range(0, 99);
			if (pick < 8)
				item.node_a = '0;
			pick = $urandom_range(0, 99);
			if (pick < 15)
				item.node_b = item.node_a;
			else if (pick < 50)
				item.node_b = jump_mirror[item.node_a][$urandom_range(0, LIFT_LEVELS - 1)];
			else if (pick < 58)
				item.node_b = '0;
			else
				item.node_b = pick_placed();
		end
		return item;
	endfunction

	// Offers one item after a random gap and records its expected result once accepted.
	task automatic offer_item(input req_item_t item, input logic fixed, input rsp_item_t want);
		int        gap;
		rsp_item_t predicted;
		pending_t  entry;
		gap = ((items_sent / 48) % 5 == 4) ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req       <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		predicted  = apply_tree_op(item);
		entry.stim = item;
		entry.want = fixed ? want : predicted;
		pending_results = {pending_results, entry};
		items_sent++;
	endtask

	// Stops offering until every outstanding result has come back.
	task automatic drain_results();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin : stimulus
		logic [NODE_W-1:0] chain_tail;
		logic [NODE_W-1:0] leaf_one;
		logic [NODE_W-1:0] leaf_two;
		int                step;
		int                walk;
		arst_n         = 1'b0;
		req_valid      = 1'b0;
		req            = '0;
		items_sent     = 0;
		mismatch_count = 0;
		last_fresh     = '0;
		foreach (depth_mirror[n]) begin
			depth_mirror[n] = '0;
			present[n]      = 1'b0;
		end
		foreach (jump_mirror[n, lvl])
			jump_mirror[n][lvl] = '0;
		present[0] = 1'b1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[row])
			offer_item(DIRECTED[row].stim, DIRECTED[row].fixed, DIRECTED[row].want);
		drain_results();

		// Random phase. Halfway through, the sender goes quiet until the block is empty.
		for (step = 0; step < RANDOM_ITEMS; step++) begin
			if (step == RANDOM_ITEMS / 2)
				drain_results();
			offer_item(random_tree_op(), 1'b0, '0);
		end

		// Two children of the deepest node, then that node is pulled back to the root,
		// which leaves the children's rows pointing through a node that now sits high up.
		chain_tail = placed[0];
		foreach (placed[i])
			if (depth_mirror[placed[i]] > depth_mirror[chain_tail])
				chain_tail = placed[i];
		walk = 0;
		while (placed[walk] == chain_tail)
			walk++;
		leaf_one = placed[walk];
		walk++;
		while (placed[walk] == chain_tail)
			walk++;
		leaf_two = placed[walk];
		offer_item('{FUNC_INSERT, leaf_one, chain_tail}, 1'b0, '0);
		offer_item('{FUNC_INSERT, leaf_two, chain_tail}, 1'b0, '0);
		offer_item('{FUNC_INSERT, chain_tail, 10'd0}, 1'b1, '{10'd0, 11'd1});
		offer_item('{FUNC_QUERY, leaf_one, leaf_two}, 1'b0, '0);
		offer_item('{FUNC_QUERY, chain_tail, leaf_one}, 1'b0, '0);
		offer_item('{FUNC_QUERY, leaf_two, 10'd0}, 1'b0, '0);

		req_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("tree_lca_binary_lifting_unit verification clean");
		else
			$display("tree_lca_binary_lifting_unit verification failed");
		$finish;
	end

	// Receiver: random back-pressure, one long hold-off so that the block fills up and
	// stalls its input, and quiet stretches with ready held high.
	initial begin : result_checker
		int       hold;
		pending_t head;
		string    op;
		rsp_ready    = 1'b0;
		results_seen = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (results_seen == LONG_HOLD_AT)
				hold = LONG_HOLD_CYCLES;
			else if ((results_seen / 40) % 5 == 2)
				hold = 0;
			else
				hold = $urandom_range(0, 13);
			if (hold > 0) begin
				rsp_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			@(posedge clk);
			while (!rsp_valid)
				@(posedge clk);
			results_seen++;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result common_ancestor %0d distance %0d",
					$time, rsp.common_ancestor, rsp.distance);
				mismatch_count++;
			end else begin
				head = pending_results.pop_front();
				op   = (head.stim.func == FUNC_QUERY) ? "query" : "insert";
				if (rsp.common_ancestor !== head.want.common_ancestor) begin
					$display("%0t: %s %0d,%0d common_ancestor expected %0d, got %0d",
						$time, op, head.stim.node_a, head.stim.node_b,
						head.want.common_ancestor, rsp.common_ancestor);
					mismatch_count++;
				end
				if (rsp.distance !== head.want.distance) begin
					$display("%0t: %s %0d,%0d distance expected %0d, got %0d",
						$time, op, head.stim.node_a, head.stim.node_b,
						head.want.distance, rsp.distance);
					mismatch_count++;
				end
			end
		end
	end

	// Ends the run if neither channel completes a handshake for too long.
	initial begin : stall_watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
		$display("tree_lca_binary_lifting_unit verification failed");
		$finish;
	end

endmodule
